// File: hw/rtl/npc_pkg.sv
// nearest palette color: shared types and constants
// no dependencies; imported by the interfaces, controller, datapath, top level and checker

package npc_pkg;

  localparam int COMP_W  = 8;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int INDEX_W = 8;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = 18;

  // larger than any real distance, so entry 0 always wins the first compare
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 3);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COMP_W-1:0]  comp_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DIST_W-1:0]  dist_t;

  // controller to datapath
  typedef struct packed {
    logic wr_entry;    // store the input beat in the palette
    logic cache_clr;   // drop the cached answer
    logic query_start; // latch the query color, restart the address counter
    logic rd_en;       // read one palette entry
    logic emit;        // load the output register
    logic use_search;  // answer comes from the search, not the cache
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cache_hit;
    logic rd_last;
    logic pipe_busy;
  } dp_sts_t;

endpackage

// File: hw/rtl/npc_if.sv
// valid/ready channel interfaces for the nearest palette color block
// depends on npc_pkg

interface npc_in_if
  import npc_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  opcode;
  logic [INDEX_W-1:0] entry_index;
  comp_t red;
  comp_t green;
  comp_t blue;

  modport source (output valid, opcode, entry_index, red, green, blue, input ready);
  modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if
  import npc_pkg::*;
;
  logic valid;
  logic ready;
  logic [INDEX_W-1:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink   (input valid, best_index, output ready);
endinterface

interface npc_cfg_if;
  logic valid;
  logic ready;
  logic swap_red_blue;

  modport source (output valid, swap_red_blue, input ready);
  modport sink   (input valid, swap_red_blue, output ready);
endinterface

// File: hw/rtl/npc_ctrl.sv
// nearest palette color controller: sequences writes, cache hits and searches
// depends on npc_pkg

module npc_ctrl
  import npc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       use_search_r, use_search_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    use_search_nxt = use_search_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd            = '0;
    cmd.use_search = use_search_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_WRITE) begin
            cmd.wr_entry  = 1'b1;
            cmd.cache_clr = 1'b1;
          end else if (sts.cache_hit) begin
            use_search_nxt = 1'b0;
            state_nxt      = S_EMIT;
          end else begin
            cmd.query_start = 1'b1;
            use_search_nxt  = 1'b1;
            state_nxt       = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      use_search_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      use_search_r <= use_search_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/npc_dp.sv
// nearest palette color datapath: palette memory, cache, distance pipeline
// depends on npc_pkg

module npc_dp
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int IDX_W           = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  comp_t              in_red,
  input  comp_t              in_green,
  input  comp_t              in_blue,
  input  logic               cfg_we,
  input  logic               cfg_swap,
  output logic [INDEX_W-1:0] best_index
);

  color_t mem [PALETTE_ENTRIES];

  logic               swap_r;
  color_t             q_color_r;
  color_t             cached_color_r;
  logic               cache_vld_r;
  logic [IDX_W-1:0]   cached_idx_r;
  logic [IDX_W-1:0]   addr_r;
  color_t             rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  logic [SQ_W-1:0]    sq_r [3];
  logic [IDX_W-1:0]   sq_idx_r;
  logic               sq_vld_r;
  dist_t              best_dist_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [INDEX_W-1:0] out_best_r, out_best_nxt;

  color_t             in_color;
  logic               in_range;
  comp_t              diff [3];
  dist_t              dist_sum;

  // swap applies to queries only; writes store the beat as given
  assign in_color = swap_r ? {in_blue, in_green, in_red} : {in_red, in_green, in_blue};
  assign in_range = {1'b0, in_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);

  assign sts.cache_hit = cache_vld_r && (in_color == cached_color_r);
  assign sts.rd_last   = (addr_r == IDX_W'(PALETTE_ENTRIES - 1));
  assign sts.pipe_busy = rd_vld_r || sq_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      swap_r <= cfg_swap;
    end
  end

  // single-port palette memory
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && in_range) begin
      mem[in_entry_index[IDX_W-1:0]] <= {in_red, in_green, in_blue};
    end else if (cmd.rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      addr_r <= '0;
    end else if (cmd.rd_en) begin
      addr_r <= addr_r + 1'b1;
    end
    if (cmd.rd_en) begin
      rd_idx_r <= addr_r;
    end
    if (cmd.query_start) begin
      q_color_r <= in_color;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (rd_data_r[k*COMP_W +: COMP_W] > q_color_r[k*COMP_W +: COMP_W])
              ? rd_data_r[k*COMP_W +: COMP_W] - q_color_r[k*COMP_W +: COMP_W]
              : q_color_r[k*COMP_W +: COMP_W] - rd_data_r[k*COMP_W +: COMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SQ_W'(diff[k]) * SQ_W'(diff[k]);
      end
      sq_idx_r <= rd_idx_r;
    end
  end

  assign dist_sum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_dist_r <= DIST_START;
      best_idx_r  <= '0;
    end else if (sq_vld_r && (dist_sum < best_dist_r)) begin
      best_dist_r <= dist_sum;
      best_idx_r  <= sq_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r    <= 1'b0;
      cached_color_r <= '0;
      cached_idx_r   <= '0;
    end else begin
      if (cmd.cache_clr) begin
        cache_vld_r <= 1'b0;
      end else if (cmd.emit && cmd.use_search) begin
        cache_vld_r  <= 1'b1;
        cached_idx_r <= best_idx_r;
      end
      if (cmd.query_start) begin
        cached_color_r <= in_color;
      end
    end
  end

  always_comb begin
    out_best_nxt = '0;
    out_best_nxt[IDX_W-1:0] = cmd.use_search ? best_idx_r : cached_idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_best_r <= out_best_nxt;
    end
  end

  assign best_index = out_best_r;

endmodule

// File: hw/rtl/nearest_palette_color_top.sv
// nearest palette color search, top level
// depends on npc_pkg, npc_if, npc_ctrl, npc_dp
//
// in_if  : one beat per item; a write stores red/green/blue at entry_index
//          (indexes at or above PALETTE_ENTRIES are dropped), a query asks
//          for the nearest palette entry
// out_if : one beat per query carrying best_index; writes give no beat
// cfg_if : one beat sets swap_red_blue (query color arrives as bgr);
//          always ready, write it only while the block is idle
// write beat: accepted in the idle state, in_if.ready stays high
// cache hit (same color as the last query, no write since): the accept moves
//   the controller to S_EMIT, which loads the output register once it is free
// search: every palette entry is read through the single read port of the
//   palette memory, then the square and compare stages drain before the output
//   register loads; in_if.ready is low from a query's accept until its result is
//   loaded, so a query may be accepted while the previous result still waits there
// reset: rst_n clears the controller, the cache and swap_red_blue; palette
//   contents are undefined until written
// stall: a held result keeps out_if.valid and best_index steady; a finished
//   search waits until the output register frees

module nearest_palette_color_top
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic        clk,
  input logic        rst_n,
  npc_in_if.sink     in_if,
  npc_out_if.source  out_if,
  npc_cfg_if.sink    cfg_if
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes land straight in the datapath register
  assign cfg_if.ready = 1'b1;

  npc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npc_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .IDX_W           (IDX_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_entry_index (in_if.entry_index),
    .in_red         (in_if.red),
    .in_green       (in_if.green),
    .in_blue        (in_if.blue),
    .cfg_we         (cfg_if.valid),
    .cfg_swap       (cfg_if.swap_red_blue),
    .best_index     (out_if.best_index)
  );

endmodule

// File: hw/rtl/npc_checker.sv
// port-level checks for the nearest palette color block, with its bind
// depends on npc_pkg and nearest_palette_color_top

module npc_checker
  import npc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] best_index
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(best_index))
    else $error("result dropped or changed under stall");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a palette write never produces a result beat (checked while no result is pending)
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_WRITE) && !out_valid |=> !out_valid)
    else $error("result appeared after a palette write");

  // an accepted query drops in_ready (the design keeps it low until its answer is loaded)
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_QUERY) |=> !in_ready)
    else $error("input ready right after a query");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_opcode  (in_if.opcode),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .best_index (out_if.best_index)
);
